@@ rtl/core/latency_histogram_monitor_top_defines.svh @@
// Assertion macros shared by the latency histogram monitor checkers.
`ifndef LATENCY_HISTOGRAM_MONITOR_TOP_DEFINES_SVH
`define LATENCY_HISTOGRAM_MONITOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define LHM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define LHM_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/lhm_pkg.sv @@
// Types, constants and codes of the latency histogram monitor.
package lhm_pkg;

   localparam int NUM_TYPES_DEF  = 16;
   localparam int NUM_LIMITS_DEF = 4;
   localparam int LIMIT_SLOTS    = 4;
   localparam int LIMIT_IDX_W    = 2;
   localparam int LIMIT_W        = 20;
   localparam int TYPE_W         = 4;
   localparam int TIME_W         = 64;
   localparam int BKT_W          = 3;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = 2;
   localparam int ADDR_W         = 5;
   localparam int DATA_W         = 32;
   localparam int REG_IDX_W      = 3;

   localparam logic [TIME_W-1:0] ALL_ONES64 = '1;

   typedef enum logic [1:0] {
      KIND_RECORD = 2'd0,
      KIND_READ   = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ENABLE = 3'd0,
      REG_LIMIT0 = 3'd1,
      REG_LIMIT1 = 3'd2,
      REG_LIMIT2 = 3'd3,
      REG_LIMIT3 = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [TYPE_W-1:0] probe_type;
      logic [TIME_W-1:0] start_time;
      logic [TIME_W-1:0] now_time;
   } req_type;

   typedef struct packed {
      logic [TYPE_W-1:0] type_out;
      logic [TIME_W-1:0] sample_count;
      logic [TIME_W-1:0] latency_sum;
      logic [TIME_W-1:0] latency_min;
      logic [TIME_W-1:0] latency_max;
      logic [BKT_W-1:0]  bucket_index;
      logic [TIME_W-1:0] bucket_count;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic                                   record_enable;
      logic [LIMIT_SLOTS-1:0][LIMIT_W-1:0]    bucket_limit;
   } cfg_type;

   typedef struct packed {
      op_type            op;
      logic [TYPE_W-1:0] probe_type;
      logic              type_ok;
      logic [TIME_W-1:0] latency;
      logic [BKT_W-1:0]  bkt;
      logic              bkt_en;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   typedef struct packed {
      logic [TIME_W-1:0] count;
      logic [TIME_W-1:0] sum;
      logic [TIME_W-1:0] min;
      logic [TIME_W-1:0] max;
   } stat_type;

   localparam stat_type STAT_RESET = '{count: '0, sum: '0, min: '1, max: '0};

endpackage

@@ rtl/core/lhm_csr.sv @@
// Configuration registers behind the APB-style port.
module lhm_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [lhm_pkg::ADDR_W-1:0]   paddr,
   input  logic [lhm_pkg::DATA_W-1:0]   pwdata,
   output logic [lhm_pkg::DATA_W-1:0]   prdata,
   output logic                         pready,
   output lhm_pkg::cfg_type             cfg
);
   import lhm_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   reg_idx_type reg_idx;
   logic        wr_en;

   assign reg_idx = reg_idx_type'(paddr[ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ENABLE: cfg_in.record_enable   = pwdata[0];
            REG_LIMIT0: cfg_in.bucket_limit[0] = pwdata[LIMIT_W-1:0];
            REG_LIMIT1: cfg_in.bucket_limit[1] = pwdata[LIMIT_W-1:0];
            REG_LIMIT2: cfg_in.bucket_limit[2] = pwdata[LIMIT_W-1:0];
            REG_LIMIT3: cfg_in.bucket_limit[3] = pwdata[LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_ENABLE: prdata = DATA_W'(cfg_ff.record_enable);
         REG_LIMIT0: prdata = DATA_W'(cfg_ff.bucket_limit[0]);
         REG_LIMIT1: prdata = DATA_W'(cfg_ff.bucket_limit[1]);
         REG_LIMIT2: prdata = DATA_W'(cfg_ff.bucket_limit[2]);
         REG_LIMIT3: prdata = DATA_W'(cfg_ff.bucket_limit[3]);
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/lhm_front.sv @@
// Front end: accepts items, computes latency, classifies and queues them.
module lhm_front #(
   parameter int NUM_TYPES  = lhm_pkg::NUM_TYPES_DEF,
   parameter int NUM_LIMITS = lhm_pkg::NUM_LIMITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lhm_pkg::req_type      req_data,
   input  lhm_pkg::cfg_type      cfg,
   input  logic                  hold_off,
   input  lhm_pkg::q_status_type q_status,
   output logic                  push,
   output lhm_pkg::cmd_type      push_cmd
);
   import lhm_pkg::*;

   localparam int TCMP_W = 8;

   logic              stage_valid_ff, stage_valid_in;
   logic [1:0]        stage_kind_ff;
   logic [TYPE_W-1:0] stage_type_ff;
   logic [TIME_W-1:0] stage_lat_ff;
   logic              stage_timed_ff;
   logic              stage_ok_ff;
   logic              accept;
   logic              keep;
   logic              found;
   logic [BKT_W-1:0]  bkt;
   op_type            op;

   assign busy   = hold_off || (stage_valid_ff && q_status.full);
   assign accept = start && !busy;

   always_comb begin
      keep = 1'b0;
      op   = OP_RECORD;
      case (stage_kind_ff)
         KIND_RECORD: begin
            keep = cfg.record_enable && stage_timed_ff && stage_ok_ff;
            op   = OP_RECORD;
         end
         KIND_READ: begin
            keep = 1'b1;
            op   = OP_READ;
         end
         KIND_CLEAR: begin
            keep = 1'b1;
            op   = OP_CLEAR;
         end
         default: keep = 1'b0;
      endcase
   end

   always_comb begin
      found = 1'b0;
      bkt   = BKT_W'(NUM_LIMITS);
      for (int i = 0; i < NUM_LIMITS; i++) begin
         if (!found && stage_lat_ff <= TIME_W'(cfg.bucket_limit[LIMIT_IDX_W'(i)])) begin
            found = 1'b1;
            bkt   = BKT_W'(i);
         end
      end
   end

   assign push = stage_valid_ff && keep && !q_status.full;

   always_comb begin
      push_cmd.op         = op;
      push_cmd.probe_type = stage_type_ff;
      push_cmd.type_ok    = stage_ok_ff;
      push_cmd.latency    = stage_lat_ff;
      push_cmd.bkt        = bkt;
      push_cmd.bkt_en     = cfg.bucket_limit[0] != '0;
   end

   assign stage_valid_in = accept || (stage_valid_ff && keep && q_status.full);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_kind_ff  <= req_data.kind;
         stage_type_ff  <= req_data.probe_type;
         stage_lat_ff   <= req_data.now_time - req_data.start_time;
         stage_timed_ff <= req_data.start_time != '0;
         stage_ok_ff    <= TCMP_W'(req_data.probe_type) < TCMP_W'(NUM_TYPES);
      end
   end

endmodule

@@ rtl/core/lhm_queue.sv @@
// Short command queue between the front end and the back end.
module lhm_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lhm_pkg::cmd_type      push_cmd,
   input  logic                  pop,
   output lhm_pkg::cmd_type      head,
   output lhm_pkg::q_status_type q_status
);
   import lhm_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign head           = entry_ff[rd_ptr_ff];
   assign q_status.empty = count_ff == '0;
   assign q_status.full  = count_ff == (QPTR_W+1)'(QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/core/lhm_back.sv @@
// Back end: statistics memory, record update, read-out and clearing sweep.
module lhm_back #(
   parameter int NUM_TYPES  = lhm_pkg::NUM_TYPES_DEF,
   parameter int NUM_LIMITS = lhm_pkg::NUM_LIMITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lhm_pkg::cmd_type      head,
   input  lhm_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  sweep_busy,
   output logic                  rsp_strobe,
   output lhm_pkg::rsp_type      rsp_data
);
   import lhm_pkg::*;

   localparam int NB = NUM_LIMITS + 1;
   localparam int BW = $clog2(NB);
   localparam int TW = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;

   typedef logic [NB-1:0][TIME_W-1:0] bkt_row_type;

   typedef enum logic [1:0] {
      S_SWEEP,
      S_IDLE,
      S_UPDATE,
      S_EMIT
   } state_type;

   stat_type    stat_mem [NUM_TYPES];
   bkt_row_type bkt_mem  [NUM_TYPES];

   stat_type    stat_rd_ff;
   bkt_row_type bkt_rd_ff;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff, cmd_in;
   logic [TW-1:0] sweep_ff, sweep_in;
   logic [BW-1:0] b_ff, b_in;
   logic        init_ff, init_in;
   logic        rsp_strobe_ff, rsp_strobe_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        wr_en;
   logic [TW-1:0] wr_addr;
   stat_type    wr_stat, new_stat;
   bkt_row_type wr_bkt, new_bkt;
   logic [BW-1:0] sel;
   logic        at_last;

   assign sel        = cmd_ff.bkt[BW-1:0];
   assign at_last    = b_ff == BW'(NB - 1);
   assign sweep_busy = init_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      new_stat.count = stat_rd_ff.count + 64'd1;
      new_stat.sum   = stat_rd_ff.sum + cmd_ff.latency;
      new_stat.min   = (cmd_ff.latency < stat_rd_ff.min) ? cmd_ff.latency : stat_rd_ff.min;
      new_stat.max   = (cmd_ff.latency > stat_rd_ff.max) ? cmd_ff.latency : stat_rd_ff.max;
      new_bkt        = bkt_rd_ff;
      if (cmd_ff.bkt_en) begin
         new_bkt[sel] = bkt_rd_ff[sel] + 64'd1;
      end
   end

   always_comb begin
      wr_en   = (state_ff == S_SWEEP) || (state_ff == S_UPDATE);
      wr_addr = (state_ff == S_SWEEP) ? sweep_ff : TW'(cmd_ff.probe_type);
      wr_stat = (state_ff == S_SWEEP) ? STAT_RESET : new_stat;
      wr_bkt  = (state_ff == S_SWEEP) ? '0 : new_bkt;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      sweep_in      = sweep_ff;
      b_in          = b_ff;
      init_in       = init_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      pop           = 1'b0;
      case (state_ff)
         S_SWEEP: begin
            if (sweep_ff == TW'(NUM_TYPES - 1)) begin
               state_in = S_IDLE;
               init_in  = 1'b0;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               cmd_in = head;
               case (head.op)
                  OP_RECORD: state_in = S_UPDATE;
                  OP_READ: begin
                     state_in = S_EMIT;
                     b_in     = '0;
                  end
                  OP_CLEAR: begin
                     state_in = S_SWEEP;
                     sweep_in = '0;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_UPDATE: state_in = S_IDLE;
         S_EMIT: begin
            rsp_strobe_in            = 1'b1;
            rsp_data_in.type_out     = cmd_ff.probe_type;
            rsp_data_in.sample_count = cmd_ff.type_ok ? stat_rd_ff.count : '0;
            rsp_data_in.latency_sum  = cmd_ff.type_ok ? stat_rd_ff.sum : '0;
            rsp_data_in.latency_min  = cmd_ff.type_ok ? stat_rd_ff.min : ALL_ONES64;
            rsp_data_in.latency_max  = cmd_ff.type_ok ? stat_rd_ff.max : '0;
            rsp_data_in.bucket_index = BKT_W'(b_ff);
            rsp_data_in.bucket_count = cmd_ff.type_ok ? bkt_rd_ff[b_ff] : '0;
            rsp_data_in.last         = at_last;
            if (at_last) begin
               state_in = S_IDLE;
            end else begin
               b_in = b_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         sweep_ff      <= '0;
         init_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sweep_ff      <= sweep_in;
         init_ff       <= init_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      cmd_ff      <= cmd_in;
      b_ff        <= b_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         stat_mem[wr_addr] <= wr_stat;
         bkt_mem[wr_addr]  <= wr_bkt;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         stat_rd_ff <= stat_mem[TW'(head.probe_type)];
         bkt_rd_ff  <= bkt_mem[TW'(head.probe_type)];
      end
   end

endmodule

@@ rtl/core/latency_histogram_monitor_top.sv @@
// Top level of the latency histogram monitor.
// Front end takes one word per cycle while the four-entry queue has room and the post-reset clear is done.
// Back end: a record updates in S_UPDATE, a read emits in S_EMIT, a clear sweeps in S_SWEEP.
// A read passes the front stage, the queue and the back end's S_EMIT state; its result words
// come one per cycle, NUM_LIMITS+1 words in all; the receiver cannot stall.
// Synchronous reset; afterwards busy stays high while memory clears.
module latency_histogram_monitor_top #(
   parameter int NUM_TYPES  = lhm_pkg::NUM_TYPES_DEF,
   parameter int NUM_LIMITS = lhm_pkg::NUM_LIMITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  lhm_pkg::req_type            req_data,
   output logic                        rsp_strobe,
   output lhm_pkg::rsp_type            rsp_data,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lhm_pkg::ADDR_W-1:0]  paddr,
   input  logic [lhm_pkg::DATA_W-1:0]  pwdata,
   output logic [lhm_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import lhm_pkg::*;

   cfg_type      cfg;
   q_status_type q_status;
   cmd_type      push_cmd;
   cmd_type      head;
   logic         push;
   logic         pop;
   logic         sweep_busy;

   lhm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   lhm_front #(
      .NUM_TYPES  (NUM_TYPES),
      .NUM_LIMITS (NUM_LIMITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .cfg      (cfg),
      .hold_off (sweep_busy),
      .q_status (q_status),
      .push     (push),
      .push_cmd (push_cmd)
   );

   lhm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   lhm_back #(
      .NUM_TYPES  (NUM_TYPES),
      .NUM_LIMITS (NUM_LIMITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .q_status   (q_status),
      .pop        (pop),
      .sweep_busy (sweep_busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

@@ rtl/core/lhm_checker.sv @@
// Port-level checker for the latency histogram monitor and its bind.
`include "latency_histogram_monitor_top_defines.svh"

module lhm_checker (
   input logic             clock,
   input logic             reset,
   input logic             busy,
   input logic             rsp_strobe,
   input lhm_pkg::rsp_type rsp_data
);
   import lhm_pkg::*;

   `LHM_ASSERT_NXT(a_last_gap, rsp_strobe && rsp_data.last, !rsp_strobe, "word after last")
   `LHM_ASSERT_NXT(a_run_advance, rsp_strobe && !rsp_data.last, rsp_strobe && rsp_data.bucket_index == $past(rsp_data.bucket_index) + 3'd1, "read run broken")
   `LHM_ASSERT_NXT(a_run_same_type, rsp_strobe && !rsp_data.last, rsp_data.type_out == $past(rsp_data.type_out) && rsp_data.sample_count == $past(rsp_data.sample_count), "read run changed type")
   `LHM_ASSERT_IMP(a_run_opens_zero, rsp_strobe && !$past(rsp_strobe), rsp_data.bucket_index == 3'd0, "read run not at bucket zero")
   `LHM_ASSERT_IMP(a_sweep_after_reset, $past(reset), busy, "not busy while clearing")

endmodule

bind latency_histogram_monitor_top lhm_checker u_lhm_checker (.*);
